/* sv/fdba_pkg.sv */
package fdba_pkg;

	localparam int ALIGN_BYTES = 16;
	localparam int OFFSET_BITS = 24;

	localparam int ACTION_W   = 3;
	localparam int COUNT_W    = 16;
	localparam int BYTES_W    = 8;
	localparam int HANDLE_W   = 61;
	localparam int SEL_W      = 3;
	localparam int OUT_OFF_W  = 24;
	localparam int SIZE_W     = 30;
	localparam int SIZE_SHIFT = 31;
	localparam int CNT_W      = 25;
	localparam int PROD_W     = COUNT_W + BYTES_W;
	localparam int SZ_W       = PROD_W + 1;
	localparam int CMP_W      = (OFFSET_BITS + 2 > CNT_W + 1) ? OFFSET_BITS + 2 : CNT_W + 1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_STATIC_CAP    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TRANSIENT_CAP = CFG_IDX_W'(1);
	localparam logic [CNT_W-1:0]     CAP_RESET         = CNT_W'(16777216);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [ACTION_W-1:0] {
		ACT_ALLOC_SV     = 3'd0,
		ACT_ALLOC_SI     = 3'd1,
		ACT_ALLOC_TV     = 3'd2,
		ACT_ALLOC_TI     = 3'd3,
		ACT_FRAME        = 3'd4,
		ACT_RESET_STATIC = 3'd5,
		ACT_DECODE_V     = 3'd6,
		ACT_DECODE_I     = 3'd7
	} action_t;

	typedef struct packed {
		action_t               act;
		logic [SZ_W-1:0]       size;
		logic                  h_static;
		logic [OUT_OFF_W-1:0]  h_off;
		logic [SIZE_W-1:0]     h_size;
	} cmd_t;

	typedef struct packed {
		logic [HANDLE_W-1:0]   handle;
		logic [SEL_W-1:0]      sel;
		logic [OUT_OFF_W-1:0]  off;
		logic [SIZE_W-1:0]     size;
		logic                  ovf;
	} res_t;

endpackage

/* sv/fdba_front.sv */
module fdba_front import fdba_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [ACTION_W-1:0] action,
	input  logic [COUNT_W-1:0]  item_count,
	input  logic [BYTES_W-1:0]  item_bytes,
	input  logic [HANDLE_W-1:0] handle_in,
	output logic                cmd_valid,
	output cmd_t                cmd,
	input  logic                cmd_full
);

	logic [PROD_W-1:0] prod;
	logic [SZ_W-1:0]   rnd;
	cmd_t              nxt;
	logic              accept;
	logic              valid_s1;
	cmd_t              cmd_s1;

	always_comb begin
		prod = PROD_W'(item_count) * PROD_W'(item_bytes);
		rnd  = (SZ_W'(prod) + SZ_W'(ALIGN_BYTES - 1)) & ~SZ_W'(ALIGN_BYTES - 1);
		nxt.act      = action_t'(action);
		nxt.size     = rnd;
		nxt.h_static = handle_in[0];
		nxt.h_off    = OUT_OFF_W'(handle_in[1 +: OFFSET_BITS]);
		nxt.h_size   = handle_in[SIZE_SHIFT +: SIZE_W];
	end

	assign full      = valid_s1 && cmd_full;
	assign accept    = push && !full;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= nxt;
		end
	end

endmodule

/* sv/fdba_cmd_q.sv */
module fdba_cmd_q import fdba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic q_full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic q_empty
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full  = (cnt_q == QCNT_W'(QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* sv/fdba_back.sv */
module fdba_back import fdba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	input  logic                 cmd_empty,
	input  cmd_t                 cmd,
	output logic                 cmd_pop,
	output logic                 empty,
	input  logic                 pop,
	output res_t                 res
);

	logic [CNT_W-1:0]  static_cap_q;
	logic [CNT_W-1:0]  transient_cap_q;
	logic              active_q;
	logic [CNT_W-1:0]  sv_used_q;
	logic [CNT_W-1:0]  si_used_q;
	logic [CNT_W-1:0]  tv_used_q [2];
	logic [CNT_W-1:0]  ti_used_q [2];

	res_t              oq_q [QDEPTH];
	logic [QPTR_W-1:0] oq_wr_q;
	logic [QPTR_W-1:0] oq_rd_q;
	logic [QCNT_W-1:0] oq_cnt_q;

	logic              take;
	logic              do_pop;
	logic              is_alloc;
	logic              is_static;
	logic [CNT_W-1:0]  cur;
	logic [CNT_W-1:0]  cap;
	logic [CMP_W-1:0]  end_c;
	logic [CMP_W-1:0]  limit;
	logic              ovf;
	logic [SEL_W-1:0]  alloc_sel;
	logic [SEL_W-1:0]  dec_sel;
	res_t              nres;

	assign take    = !cmd_empty && (oq_cnt_q != QCNT_W'(QDEPTH));
	assign cmd_pop = take;
	assign empty   = (oq_cnt_q == '0);
	assign do_pop  = pop && !empty;
	assign res     = oq_q[oq_rd_q];

	always_comb begin
		is_alloc  = 1'b1;
		is_static = 1'b0;
		cur       = '0;
		cap       = transient_cap_q;
		alloc_sel = '0;
		unique case (cmd.act)
			ACT_ALLOC_SV: begin
				is_static = 1'b1;
				cur       = sv_used_q;
				cap       = static_cap_q;
				alloc_sel = SEL_W'(0);
			end
			ACT_ALLOC_SI: begin
				is_static = 1'b1;
				cur       = si_used_q;
				cap       = static_cap_q;
				alloc_sel = SEL_W'(1);
			end
			ACT_ALLOC_TV: begin
				cur       = tv_used_q[active_q];
				alloc_sel = SEL_W'(2) + {1'b0, active_q, 1'b0};
			end
			ACT_ALLOC_TI: begin
				cur       = ti_used_q[active_q];
				alloc_sel = SEL_W'(3) + {1'b0, active_q, 1'b0};
			end
			default: begin
				is_alloc = 1'b0;
			end
		endcase

		end_c = CMP_W'(cur) + CMP_W'(cmd.size);
		limit = (CMP_W'(cap) < (CMP_W'(1) << OFFSET_BITS)) ? CMP_W'(cap)
		        : (CMP_W'(1) << OFFSET_BITS);
		ovf   = (end_c > limit) || (CMP_W'(cur) >= (CMP_W'(1) << OFFSET_BITS));

		if (cmd.h_static) dec_sel = {2'b00, cmd.act[0]};
		else dec_sel = SEL_W'(2) + {1'b0, ~active_q, 1'b0} + {2'b00, cmd.act[0]};

		nres = '0;
		if (is_alloc) begin
			if (ovf) begin
				nres.ovf = 1'b1;
			end else begin
				nres.handle = HANDLE_W'(is_static) | (HANDLE_W'(cur) << 1)
				            | (HANDLE_W'(cmd.size) << SIZE_SHIFT);
				nres.sel    = alloc_sel;
				nres.off    = OUT_OFF_W'(cur);
				nres.size   = SIZE_W'(cmd.size);
			end
		end else if (cmd.act == ACT_DECODE_V || cmd.act == ACT_DECODE_I) begin
			nres.sel  = dec_sel;
			nres.off  = cmd.h_off;
			nres.size = cmd.h_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			static_cap_q    <= CAP_RESET;
			transient_cap_q <= CAP_RESET;
			active_q        <= 1'b0;
			sv_used_q       <= '0;
			si_used_q       <= '0;
			tv_used_q[0]    <= '0;
			tv_used_q[1]    <= '0;
			ti_used_q[0]    <= '0;
			ti_used_q[1]    <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_STATIC_CAP) static_cap_q <= cfg_data;
			if (cfg_we && cfg_index == REG_TRANSIENT_CAP) transient_cap_q <= cfg_data;
			if (take) begin
				unique case (cmd.act)
					ACT_ALLOC_SV: if (!ovf) sv_used_q <= CNT_W'(end_c);
					ACT_ALLOC_SI: if (!ovf) si_used_q <= CNT_W'(end_c);
					ACT_ALLOC_TV: if (!ovf) tv_used_q[active_q] <= CNT_W'(end_c);
					ACT_ALLOC_TI: if (!ovf) ti_used_q[active_q] <= CNT_W'(end_c);
					ACT_FRAME: begin
						active_q            <= ~active_q;
						tv_used_q[~active_q] <= '0;
						ti_used_q[~active_q] <= '0;
					end
					ACT_RESET_STATIC: begin
						sv_used_q <= '0;
						si_used_q <= '0;
					end
					ACT_DECODE_V, ACT_DECODE_I: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (take) oq_wr_q <= oq_wr_q + 1'b1;
			if (do_pop) oq_rd_q <= oq_rd_q + 1'b1;
			if (take && !do_pop) oq_cnt_q <= oq_cnt_q + 1'b1;
			else if (do_pop && !take) oq_cnt_q <= oq_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			oq_q[oq_wr_q] <= nres;
		end
	end

endmodule

/* sv/frame_double_buffered_bump_allocator_unit.sv */
// bump allocator for vertex and index ranges, double buffered by frame
// input channel: push/full with action, item_count, item_bytes, handle_in;
//   a beat is taken when push is high and full is low
// result channel: empty/pop with handle_out, buffer_select, range_offset,
//   range_size, overflow; the oldest result is shown while empty is low
// config: cfg_we/cfg_index/cfg_data, no read-back
// every input beat gives exactly one result beat
// path: a taken input beat goes through the front register to the command
//   queue, then the back end executes it into the result queue
// throughput: one beat per cycle while full stays low; the counter compare
//   is combinational and its update is registered on the same take, so
//   back-to-back allocations from the same counter need no wait
// reset: counters cleared, active frame 0, both capacities 2^24,
//   both queues empty
// a stalled receiver fills the two-entry result queue, then the command
//   queue, then the front register, after which full rises
module frame_double_buffered_bump_allocator_unit import fdba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic [ACTION_W-1:0]  action,
	input  logic [COUNT_W-1:0]   item_count,
	input  logic [BYTES_W-1:0]   item_bytes,
	input  logic [HANDLE_W-1:0]  handle_in,
	output logic                 empty,
	input  logic                 pop,
	output logic [HANDLE_W-1:0]  handle_out,
	output logic [SEL_W-1:0]     buffer_select,
	output logic [OUT_OFF_W-1:0] range_offset,
	output logic [SIZE_W-1:0]    range_size,
	output logic                 overflow
);

	logic cmd_valid;
	cmd_t front_cmd;
	logic cq_full;
	logic cq_empty;
	logic cq_pop;
	cmd_t back_cmd;
	res_t res;

	fdba_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.item_count (item_count),
		.item_bytes (item_bytes),
		.handle_in  (handle_in),
		.cmd_valid  (cmd_valid),
		.cmd        (front_cmd),
		.cmd_full   (cq_full)
	);

	fdba_cmd_q u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_data (front_cmd),
		.q_full  (cq_full),
		.rd_en   (cq_pop),
		.rd_data (back_cmd),
		.q_empty (cq_empty)
	);

	fdba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_empty (cq_empty),
		.cmd       (back_cmd),
		.cmd_pop   (cq_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign handle_out    = res.handle;
	assign buffer_select = res.sel;
	assign range_offset  = res.off;
	assign range_size    = res.size;
	assign overflow      = res.ovf;

endmodule

/* dv/bump_alloc_checker.sv */
module bump_alloc_checker import fdba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	input  logic                 push,
	input  logic                 full,
	input  logic [ACTION_W-1:0]  action,
	input  logic [COUNT_W-1:0]   item_count,
	input  logic [BYTES_W-1:0]   item_bytes,
	input  logic [HANDLE_W-1:0]  handle_in,
	input  logic                 empty,
	input  logic                 pop,
	input  logic [HANDLE_W-1:0]  handle_out,
	input  logic [SEL_W-1:0]     buffer_select,
	input  logic [OUT_OFF_W-1:0] range_offset,
	input  logic [SIZE_W-1:0]    range_size,
	input  logic                 overflow,
	output int                   pending,
	output int                   fails
);

	logic             frame_q;
	logic [CNT_W-1:0] static_cap;
	logic [CNT_W-1:0] trans_cap;
	logic [CNT_W-1:0] sv_used;
	logic [CNT_W-1:0] si_used;
	logic [CNT_W-1:0] tv_used [2];
	logic [CNT_W-1:0] ti_used [2];
	res_t             pending_ranges [$];

	// bump one counter; on overflow the counter stays put and the result is zero apart from its overflow flag
	function automatic res_t carve_range(input logic [CNT_W-1:0] used,
			input logic [CNT_W-1:0] cap, input logic is_static,
			input logic [SEL_W-1:0] sel, input logic [COUNT_W-1:0] cnt,
			input logic [BYTES_W-1:0] nb, output logic [CNT_W-1:0] used_nxt);
		logic [CNT_W:0] sz;
		logic [CNT_W:0] fin;
		logic [CNT_W:0] lim;
		res_t r;
		sz = (((CNT_W+1)'(cnt) * (CNT_W+1)'(nb) + (CNT_W+1)'(ALIGN_BYTES - 1))
			/ (CNT_W+1)'(ALIGN_BYTES)) * (CNT_W+1)'(ALIGN_BYTES);
		lim = (CNT_W+1)'(1) << OFFSET_BITS;
		if ({1'b0, cap} < lim)
			lim = {1'b0, cap};
		fin = {1'b0, used} + sz;
		used_nxt = used;
		r = '0;
		if (fin > lim || used > CNT_W'((1 << OFFSET_BITS) - 1)) begin
			r.ovf = 1'b1;
		end else begin
			used_nxt = fin[CNT_W-1:0];
			r.handle = (HANDLE_W'(sz) << SIZE_SHIFT) | (HANDLE_W'(used) << 1)
				| HANDLE_W'(is_static);
			r.sel = sel;
			r.off = used[OUT_OFF_W-1:0];
			r.size = SIZE_W'(sz);
		end
		return r;
	endfunction

	function automatic res_t apply_action(input action_t a, input logic [COUNT_W-1:0] cnt,
			input logic [BYTES_W-1:0] nb, input logic [HANDLE_W-1:0] h);
		res_t r;
		logic kind;
		r = '0;
		kind = (a == ACT_DECODE_I);
		case (a)
			ACT_ALLOC_SV: r = carve_range(sv_used, static_cap, 1'b1, SEL_W'(0), cnt, nb,
				sv_used);
			ACT_ALLOC_SI: r = carve_range(si_used, static_cap, 1'b1, SEL_W'(1), cnt, nb,
				si_used);
			ACT_ALLOC_TV: r = carve_range(tv_used[frame_q], trans_cap, 1'b0,
				SEL_W'(2 + 2 * int'(frame_q)), cnt, nb, tv_used[frame_q]);
			ACT_ALLOC_TI: r = carve_range(ti_used[frame_q], trans_cap, 1'b0,
				SEL_W'(3 + 2 * int'(frame_q)), cnt, nb, ti_used[frame_q]);
			ACT_FRAME: begin
				frame_q = ~frame_q;
				tv_used[frame_q] = '0;
				ti_used[frame_q] = '0;
			end
			ACT_RESET_STATIC: begin
				sv_used = '0;
				si_used = '0;
			end
			default: begin
				// non-static handles point at the render frame
				r.off = h[OFFSET_BITS:1];
				r.size = h[SIZE_SHIFT +: SIZE_W];
				if (h[0])
					r.sel = SEL_W'(kind);
				else
					r.sel = SEL_W'(2 + 2 * int'(!frame_q) + int'(kind));
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0h, got %0h", name, want, seen);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			frame_q = 1'b0;
			static_cap = CAP_RESET;
			trans_cap = CAP_RESET;
			sv_used = '0;
			si_used = '0;
			tv_used[0] = '0;
			tv_used[1] = '0;
			ti_used[0] = '0;
			ti_used[1] = '0;
			pending_ranges.delete();
			fails = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STATIC_CAP:    static_cap = cfg_data;
					REG_TRANSIENT_CAP: trans_cap = cfg_data;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (pending_ranges.size() == 0) begin
					$error("result beat with nothing pending");
					fails++;
				end else begin
					want = pending_ranges.pop_front();
					check_field("handle_out", 64'(want.handle), 64'(handle_out));
					check_field("buffer_select", 64'(want.sel), 64'(buffer_select));
					check_field("range_offset", 64'(want.off), 64'(range_offset));
					check_field("range_size", 64'(want.size), 64'(range_size));
					check_field("overflow", 64'(want.ovf), 64'(overflow));
				end
			end
			if (push && !full)
				pending_ranges.push_back(apply_action(action_t'(action), item_count,
					item_bytes, handle_in));
		end
		pending = pending_ranges.size();
	end

endmodule

/* dv/tb_top.sv */
module tb_top;
	import fdba_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0]     cfg_data = '0;
	logic                 push = 1'b0;
	logic                 full;
	logic [ACTION_W-1:0]  action = '0;
	logic [COUNT_W-1:0]   item_count = '0;
	logic [BYTES_W-1:0]   item_bytes = '0;
	logic [HANDLE_W-1:0]  handle_in = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [HANDLE_W-1:0]  handle_out;
	logic [SEL_W-1:0]     buffer_select;
	logic [OUT_OFF_W-1:0] range_offset;
	logic [SIZE_W-1:0]    range_size;
	logic                 overflow;
	int                   pending;
	int                   fails;
	int                   send_burst = 0;

	always #4 clk = ~clk;

	frame_double_buffered_bump_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full),
		.action(action), .item_count(item_count), .item_bytes(item_bytes),
		.handle_in(handle_in),
		.empty(empty), .pop(pop),
		.handle_out(handle_out), .buffer_select(buffer_select),
		.range_offset(range_offset), .range_size(range_size), .overflow(overflow)
	);

	bump_alloc_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full),
		.action(action), .item_count(item_count), .item_bytes(item_bytes),
		.handle_in(handle_in),
		.empty(empty), .pop(pop),
		.handle_out(handle_out), .buffer_select(buffer_select),
		.range_offset(range_offset), .range_size(range_size), .overflow(overflow),
		.pending(pending), .fails(fails)
	);

	function automatic logic [HANDLE_W-1:0] rand_handle();
		return HANDLE_W'({$urandom, $urandom});
	endfunction

	task automatic offer(input action_t a, input logic [COUNT_W-1:0] c,
			input logic [BYTES_W-1:0] b, input logic [HANDLE_W-1:0] h);
		int n;
		if (send_burst > 0) begin
			send_burst--;
			n = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			send_burst = $urandom_range(10, 30);
			n = 0;
		end else begin
			n = $urandom_range(0, 17);
		end
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
		push <= 1'b1;
		action <= a;
		item_count <= c;
		item_bytes <= b;
		handle_in <= h;
		do @(posedge clk); while (full);
	endtask

	task automatic offer_random();
		int r;
		int k;
		action_t a;
		logic [COUNT_W-1:0] c;
		r = $urandom_range(0, 99);
		if (r < 15)      a = ACT_ALLOC_SV;
		else if (r < 30) a = ACT_ALLOC_SI;
		else if (r < 45) a = ACT_ALLOC_TV;
		else if (r < 60) a = ACT_ALLOC_TI;
		else if (r < 68) a = ACT_FRAME;
		else if (r < 72) a = ACT_RESET_STATIC;
		else if (r < 86) a = ACT_DECODE_V;
		else             a = ACT_DECODE_I;
		k = $urandom_range(0, 9);
		if (k < 6)      c = COUNT_W'($urandom_range(0, 64));
		else if (k < 9) c = COUNT_W'($urandom_range(0, 4095));
		else            c = COUNT_W'($urandom_range(0, 65535));
		offer(a, c, BYTES_W'($urandom_range(0, 255)), rand_handle());
	endtask

	// drop push and wait for every pending result to drain
	task automatic settle();
		push <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic set_caps(input logic [CNT_W-1:0] s, input logic [CNT_W-1:0] t);
		cfg_we <= 1'b1;
		cfg_index <= REG_STATIC_CAP;
		cfg_data <= s;
		@(posedge clk);
		cfg_index <= REG_TRANSIENT_CAP;
		cfg_data <= t;
		@(posedge clk);
		cfg_index <= $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
		cfg_data <= CNT_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		#2000000;
		$display("tb_top: errors");
		$finish;
	end

	// receiver side, with two long hold-offs to back the block up
	initial begin
		int n;
		int got;
		int burst;
		got = 0;
		burst = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (burst > 0) begin
				burst--;
				n = 0;
			end else if ($urandom_range(0, 15) == 0) begin
				burst = $urandom_range(10, 30);
				n = 0;
			end else begin
				n = $urandom_range(0, 17);
			end
			if (got == 120 || got == 360)
				n = 150;
			if (n > 0) begin
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got++;
		end
	end

	initial begin
		int s_cap;
		int t_cap;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(ACT_ALLOC_SV, 0, 0, '0);
		offer(ACT_ALLOC_SV, 1, 1, '1);
		offer(ACT_ALLOC_SI, 16'hFFFF, 8'hFF, '0);
		offer(ACT_ALLOC_SI, 3, 5, '0);
		offer(ACT_ALLOC_TV, 17, 1, '0);
		offer(ACT_ALLOC_TI, 1, 16, '0);
		offer(ACT_DECODE_V, 0, 0, '1);
		offer(ACT_DECODE_I, 0, 0, '0);
		offer(ACT_DECODE_V, 0, 0, rand_handle());
		offer(ACT_FRAME, 0, 0, '0);
		offer(ACT_ALLOC_TV, 2, 8, '0);
		offer(ACT_ALLOC_TI, 0, 200, '0);
		offer(ACT_DECODE_V, 0, 0, HANDLE_W'(2));
		offer(ACT_DECODE_I, 0, 0, rand_handle() | HANDLE_W'(1));
		offer(ACT_FRAME, 0, 0, '0);
		offer(ACT_ALLOC_TV, 5, 3, '0);
		offer(ACT_RESET_STATIC, 0, 0, '0);
		// fill the static vertex buffer to exactly the top, then one more
		offer(ACT_ALLOC_SV, 16'hFFFF, 8'hFF, '0);
		offer(ACT_ALLOC_SV, 4111, 16, '0);
		offer(ACT_ALLOC_SV, 0, 0, '0);
		offer(ACT_ALLOC_SI, 16'hFFFF, 8'hFF, '0);
		offer(ACT_ALLOC_SI, 16'hFFFF, 8'hFF, '0);
		offer(ACT_ALLOC_SI, 1, 255, '0);
		settle();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: set_caps('0, '0);
				1: set_caps('1, CAP_RESET);
				2: begin
					s_cap = $urandom_range(0, 65536);
					t_cap = $urandom_range(0, 65536);
					set_caps(CNT_W'(s_cap), CNT_W'(t_cap));
				end
				3: begin
					t_cap = $urandom_range(1000, 300000);
					set_caps(CAP_RESET, CNT_W'(t_cap));
				end
				default: set_caps(CAP_RESET, CAP_RESET);
			endcase
			repeat (p == 0 ? 40 : 115) offer_random();
			settle();
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		if (fails == 0 && pending == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
